>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/cgf_pkg.sv
// Package with the types, widths and codes of the column ground finder.
`timescale 1ns / 1ps
`default_nettype none

package cgf_pkg;

    // Longest column that the voxel counter tracks before it saturates.
    localparam int COLUMN_DEPTH = 1024;
    localparam int CNT_W        = $clog2(COLUMN_DEPTH);

    // Fixed field widths.
    localparam int CLASS_W  = 2;
    localparam int HEIGHT_W = 32;
    localparam int GIDX_W   = 10;
    localparam int CLR_W    = 31;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Voxel occupancy classes.
    typedef enum logic [CLASS_W-1:0] {
        CLS_NULL       = 2'd0,
        CLS_UNOBSERVED = 2'd1,
        CLS_FREE       = 2'd2,
        CLS_OCCUPIED   = 2'd3
    } cls_t;

    // Register indexes, taken from paddr[2].
    typedef enum logic {
        REG_MIN_CLEARANCE = 1'b0,
        REG_VIRTUAL_SURF  = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

>>> rtl/column_ground_finder.sv
// Column ground finder top level: walks one map column and reports its ground voxel.
// Stages: the input word register, then the result word register.
// Throughput: one word per cycle unless stalled; the only loop is the state update.
// Reset: rst_n is asynchronous and active low; it clears the column state,
// both configuration registers and the valid bits of both register stages.
`timescale 1ns / 1ps
`default_nettype none

module column_ground_finder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Voxel input channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [cgf_pkg::CLASS_W-1:0]         voxel_class,
    input  wire logic signed [cgf_pkg::HEIGHT_W-1:0] voxel_elev,
    input  wire logic                                last_in_column,
    // Result channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     found,
    output logic [cgf_pkg::GIDX_W-1:0]               ground_index,
    output logic signed [cgf_pkg::HEIGHT_W-1:0]      ground_height,
    output logic signed [cgf_pkg::HEIGHT_W-1:0]      last_height,
    output logic [cgf_pkg::CLR_W-1:0]                clearance,
    output logic                                     above_seen,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cgf_pkg::APB_AW-1:0]          paddr,
    input  wire logic [cgf_pkg::APB_DW-1:0]          pwdata,
    output logic [cgf_pkg::APB_DW-1:0]               prdata,
    output logic                                     pready
);

    import cgf_pkg::*;

    localparam logic [CNT_W-1:0]    CNT_MAX    = CNT_W'(COLUMN_DEPTH - 1);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};

    // Configuration registers
    logic [CLR_W-1:0] min_clearance_reg;
    logic             virtual_surfaces_on_reg;
    reg_idx_t         reg_sel;
    logic             cfg_write;

    // Input register stage
    logic                       s1_valid_reg, s1_valid_next;
    logic [CLASS_W-1:0]         s1_class_reg;
    logic signed [HEIGHT_W-1:0] s1_height_reg;
    logic                       s1_last_reg;

    // Column state
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CLASS_W-1:0]         prev_class_reg, prev_class_next;
    logic                       have_reg, have_next;
    logic [CNT_W-1:0]           cand_idx_reg, cand_idx_next;
    logic signed [HEIGHT_W-1:0] cand_h_reg, cand_h_next;
    logic                       seen_reg, seen_next;
    logic                       done_reg, done_next;

    // Result register stage
    logic                       out_valid_reg, out_valid_next;
    logic                       found_reg;
    logic [GIDX_W-1:0]          gidx_reg;
    logic signed [HEIGHT_W-1:0] gh_reg;
    logic signed [HEIGHT_W-1:0] lh_reg;
    logic [CLR_W-1:0]           clr_reg;
    logic                       obs_reg;

    // Combinational result of the current voxel
    logic                       res_valid;
    logic                       res_found;
    logic [GIDX_W-1:0]          res_gidx;
    logic signed [HEIGHT_W-1:0] res_gh;
    logic signed [HEIGHT_W-1:0] res_lh;
    logic [CLR_W-1:0]           res_clr;
    logic                       res_obs;

    logic                  out_free;
    logic                  advance;
    logic                  in_accept;
    logic                  is_free, is_occ, prev_unobs, trigger;
    logic                  have_after;
    logic [HEIGHT_W:0]     diff;
    logic                  diff_meets;
    logic                  brk;
    logic [CLR_W-1:0]      diff_clamped;
    logic                  col_clear;

    // Handshake: the input stage moves on whenever the result slot can take a word.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Configuration port decode.
    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            REG_MIN_CLEARANCE: prdata = APB_DW'(min_clearance_reg);
            REG_VIRTUAL_SURF:  prdata = APB_DW'(virtual_surfaces_on_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_clearance_reg       <= '0;
            virtual_surfaces_on_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_MIN_CLEARANCE)
            begin
                min_clearance_reg <= pwdata[CLR_W-1:0];
            end
            else
            begin
                virtual_surfaces_on_reg <= pwdata[0];
            end
        end
    end

    // Candidate trigger and clearance test for the voxel in the input stage.
    assign is_free    = (s1_class_reg == CLS_FREE);
    assign is_occ     = (s1_class_reg == CLS_OCCUPIED);
    assign prev_unobs = (prev_class_reg == CLS_NULL) || (prev_class_reg == CLS_UNOBSERVED);
    assign trigger    = is_occ ||
                        (virtual_surfaces_on_reg && prev_unobs && is_free && !have_reg);
    assign have_after = have_reg || trigger;

    assign diff       = {s1_height_reg[HEIGHT_W-1], s1_height_reg}
                      - {cand_h_reg[HEIGHT_W-1], cand_h_reg};
    assign diff_meets = !diff[HEIGHT_W] &&
                        (diff[HEIGHT_W-1:0] >= {1'b0, min_clearance_reg});
    assign brk        = trigger && have_reg && diff_meets;

    // Clamp the difference to the clearance range.
    always_comb
    begin
        if (diff[HEIGHT_W])
        begin
            diff_clamped = '0;
        end
        else if (diff[HEIGHT_W-1])
        begin
            diff_clamped = '1;
        end
        else
        begin
            diff_clamped = diff[CLR_W-1:0];
        end
    end

    // Column state update and result formation.
    always_comb
    begin
        count_next      = count_reg;
        prev_class_next = prev_class_reg;
        have_next       = have_reg;
        cand_idx_next   = cand_idx_reg;
        cand_h_next     = cand_h_reg;
        seen_next       = seen_reg;
        done_next       = done_reg;
        col_clear       = 1'b0;

        res_valid = 1'b0;
        res_found = 1'b0;
        res_gidx  = '0;
        res_gh    = '0;
        res_lh    = '0;
        res_clr   = '0;
        res_obs   = 1'b0;

        if (advance)
        begin
            if (done_reg)
            begin
                // Past the break: only the column end matters.
                col_clear = s1_last_reg;
            end
            else
            begin
                if (count_reg < CNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                seen_next = is_free || is_occ;

                if (brk)
                begin
                    // An occupied voxel far enough above the candidate ends the search.
                    res_valid = 1'b1;
                    res_found = 1'b1;
                    res_gidx  = GIDX_W'(cand_idx_reg);
                    res_gh    = cand_h_reg;
                    res_lh    = s1_height_reg;
                    res_clr   = diff_clamped;
                    res_obs   = seen_next;
                    if (s1_last_reg)
                    begin
                        col_clear = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    if (trigger)
                    begin
                        have_next     = 1'b1;
                        cand_idx_next = count_reg;
                        cand_h_next   = s1_height_reg;
                        seen_next     = 1'b0;
                    end
                    prev_class_next = s1_class_reg;

                    // Column end without a break. The stored clearance height always
                    // equals the candidate height here, so the clearance is zero.
                    if (s1_last_reg)
                    begin
                        res_valid = 1'b1;
                        col_clear = 1'b1;
                        if (have_after)
                        begin
                            res_found = 1'b1;
                            res_gidx  = GIDX_W'(cand_idx_next);
                            res_gh    = cand_h_next;
                            res_lh    = s1_height_reg;
                            res_obs   = seen_next;
                        end
                    end
                end
            end
        end

        // Back to the reset state for the next column.
        if (col_clear)
        begin
            count_next      = '0;
            prev_class_next = CLS_NULL;
            have_next       = 1'b0;
            cand_idx_next   = '0;
            cand_h_next     = HEIGHT_MAX;
            seen_next       = 1'b0;
            done_next       = 1'b0;
        end
    end

    // Stage valid bits.
    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_free)
        begin
            out_valid_next = advance && res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and column state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
            prev_class_reg <= CLS_NULL;
            have_reg       <= 1'b0;
            cand_idx_reg   <= '0;
            cand_h_reg     <= HEIGHT_MAX;
            seen_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            count_reg      <= count_next;
            prev_class_reg <= prev_class_next;
            have_reg       <= have_next;
            cand_idx_reg   <= cand_idx_next;
            cand_h_reg     <= cand_h_next;
            seen_reg       <= seen_next;
            done_reg       <= done_next;
        end
    end

    // Input word register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_class_reg  <= voxel_class;
            s1_height_reg <= voxel_elev;
            s1_last_reg   <= last_in_column;
        end
    end

    // Result word register, loaded only when the slot is free.
    always_ff @(posedge clk)
    begin
        if (out_free && advance && res_valid)
        begin
            found_reg <= res_found;
            gidx_reg  <= res_gidx;
            gh_reg    <= res_gh;
            lh_reg    <= res_lh;
            clr_reg   <= res_clr;
            obs_reg   <= res_obs;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign ground_index   = gidx_reg;
    assign ground_height  = gh_reg;
    assign last_height    = lh_reg;
    assign clearance      = clr_reg;
    assign above_seen     = obs_reg;

endmodule

`default_nettype wire

>>> rtl/cgf_checker.sv
// Port-level checker for the column ground finder and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cgf_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic                                found,
    input wire logic [cgf_pkg::GIDX_W-1:0]          ground_index,
    input wire logic signed [cgf_pkg::HEIGHT_W-1:0] ground_height,
    input wire logic signed [cgf_pkg::HEIGHT_W-1:0] last_height,
    input wire logic [cgf_pkg::CLR_W-1:0]           clearance,
    input wire logic                                above_seen
);

    import cgf_pkg::*;

    localparam int WORD_W = 1 + GIDX_W + 2 * HEIGHT_W + CLR_W + 1;

    logic [WORD_W-1:0] out_word;
    logic              rest_zero;
    logic              break_shape;

    // The whole result word, found flag on top.
    assign out_word    = {found, ground_index, ground_height, last_height, clearance,
                          above_seen};
    assign rest_zero   = (out_word[WORD_W-2:0] == '0);
    assign break_shape = found && above_seen && (last_height > ground_height);

    // A stalled result word holds until it is taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

    // The input side only stalls behind a full, stalled result slot.
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A column with no candidate reports an all-zero word.
    `ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid && !found, rest_zero)

    // Nonzero clearance only comes from a break on an occupied voxel above the candidate.
    `ASSERT_IMPL(a_clear_break, clk, rst_n, out_valid && clearance != '0, break_shape)

endmodule

bind column_ground_finder cgf_checker u_cgf_checker (.*);

`default_nettype wire

>>> sim/tb.sv
// Testbench for the column ground finder: a directed table, then random columns, checked by a predictor.
`timescale 1ns / 1ps

module tb;
    import cgf_pkg::*;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_VOXEL,
        ROW_SET_CLEARANCE,
        ROW_SET_VIRTUAL
    } row_kind_t;

    // One ground report as the result word carries it.
    typedef struct packed {
        logic                       found;
        logic [GIDX_W-1:0]          index;
        logic signed [HEIGHT_W-1:0] ground_h;
        logic signed [HEIGHT_W-1:0] last_h;
        logic [CLR_W-1:0]           clr;
        logic                       obs;
    } ground_rpt_t;

    // One row of the directed table; val carries the register value on write rows.
    typedef struct {
        row_kind_t                  kind;
        cls_t                       cls;
        logic signed [HEIGHT_W-1:0] val;
        logic                       fin;
        bit                         typed;
        ground_rpt_t                want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [CLASS_W-1:0]         voxel_class = '0;
    logic signed [HEIGHT_W-1:0] voxel_elev = '0;
    logic                       last_in_column = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       found;
    logic [GIDX_W-1:0]          ground_index;
    logic signed [HEIGHT_W-1:0] ground_height;
    logic signed [HEIGHT_W-1:0] last_height;
    logic [CLR_W-1:0]           clearance;
    logic                       above_seen;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_AW-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    // Predictor copy of the configuration and of the column walk state.
    logic [CLR_W-1:0]           cfg_min_clear = '0;
    logic                       cfg_virtual = 1'b0;
    int                         col_count;
    cls_t                       col_prev;
    bit                         col_have;
    logic [GIDX_W-1:0]          col_idx;
    logic signed [HEIGHT_W-1:0] col_height;
    logic signed [HEIGHT_W-1:0] col_clear_h;
    bit                         col_seen;
    bit                         col_done;

    ground_rpt_t pending_grounds[$];
    ground_rpt_t exp_r;
    stim_row_t   dir_rows[$];
    int          fail_count = 0;
    bit          calm_run = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    column_ground_finder dut (.*);

    always #6 clk = ~clk;

    // Hard limit on the whole run.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Back to the state at the start of a column.
    function automatic void column_clear();
        col_count   = 0;
        col_prev    = CLS_NULL;
        col_have    = 1'b0;
        col_idx     = '0;
        col_height  = 32'sh7FFF_FFFF;
        col_clear_h = 32'sh7FFF_FFFF;
        col_seen    = 1'b0;
        col_done    = 1'b0;
    endfunction

    // Height difference clamped into the clearance field.
    function automatic logic [CLR_W-1:0] clamp_rise(input longint d);
        if (d < 0)
            return '0;
        if (d > 64'sh7FFF_FFFF)
            return '1;
        return d[CLR_W-1:0];
    endfunction

    function automatic ground_rpt_t mk_rpt(input logic f, input logic [GIDX_W-1:0] i,
                                           input logic signed [HEIGHT_W-1:0] gh,
                                           input logic signed [HEIGHT_W-1:0] lh,
                                           input logic [CLR_W-1:0] c, input logic o);
        ground_rpt_t r;
        r.found    = f;
        r.index    = i;
        r.ground_h = gh;
        r.last_h   = lh;
        r.clr      = c;
        r.obs      = o;
        return r;
    endfunction

    // Walks one voxel through the column search; returns 1 when it gives a report.
    function automatic bit ground_model_step(input cls_t c, input logic signed [HEIGHT_W-1:0] h,
                                             input logic fin, output ground_rpt_t r);
        int     idx;
        bit     prev_open;
        bit     trig;
        longint rise;
        r = '0;
        // After a break the rest of the column is skipped.
        if (col_done)
        begin
            if (fin)
                column_clear();
            return 1'b0;
        end
        idx = col_count;
        if (col_count < COLUMN_DEPTH - 1)
            col_count++;
        prev_open = (col_prev == CLS_NULL) || (col_prev == CLS_UNOBSERVED);
        col_seen  = (c == CLS_FREE) || (c == CLS_OCCUPIED);
        trig = (c == CLS_OCCUPIED) ||
               (cfg_virtual && prev_open && c == CLS_FREE && !col_have);
        if (trig)
        begin
            // A new surface either clears the candidate by enough or replaces it.
            if (col_have)
            begin
                rise        = longint'(h) - longint'(col_height);
                col_clear_h = h;
                if (rise >= longint'(cfg_min_clear))
                begin
                    r = mk_rpt(1'b1, col_idx, col_height, h, clamp_rise(rise), col_seen);
                    if (fin)
                        column_clear();
                    else
                        col_done = 1'b1;
                    return 1'b1;
                end
            end
            col_have    = 1'b1;
            col_idx     = idx[GIDX_W-1:0];
            col_height  = h;
            col_clear_h = h;
            col_seen    = 1'b0;
        end
        col_prev = c;
        if (!fin)
            return 1'b0;
        // End of the column without a break.
        if (col_have)
            r = mk_rpt(1'b1, col_idx, col_height, h,
                       clamp_rise(longint'(col_clear_h) - longint'(col_height)), col_seen);
        column_clear();
        return 1'b1;
    endfunction

    // Offers one voxel word, waits for it to be taken and records what it should give.
    task automatic push_voxel(input cls_t c, input logic signed [HEIGHT_W-1:0] h,
                              input logic fin, input bit typed, input ground_rpt_t want);
        ground_rpt_t r;
        bit          has_r;
        while (!calm_run && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        voxel_class    <= c;
        voxel_elev     <= h;
        last_in_column <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has_r = ground_model_step(c, h, fin, r);
        if (typed)
            pending_grounds.push_back(want);
        else if (has_r)
            pending_grounds.push_back(r);
    endtask

    // Stops offering words and lets every report come out of the block.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_grounds.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Register write over the configuration port while the block is idle.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] val);
        settle_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_CLEARANCE: cfg_min_clear = val[CLR_W-1:0];
            REG_VIRTUAL_SURF:  cfg_virtual = val[0];
        endcase
    endtask

    function automatic cls_t pick_class();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return CLS_OCCUPIED;
        if (roll < 65)
            return CLS_FREE;
        if (roll < 85)
            return CLS_UNOBSERVED;
        return CLS_NULL;
    endfunction

    // One random column: mostly a walk with rising surfaces, else noise or extreme heights.
    task automatic send_column(output int sent);
        int unsigned                style;
        int                         len;
        logic signed [HEIGHT_W-1:0] h;
        cls_t                       c;
        style = $urandom_range(99);
        len   = (style < 70) ? $urandom_range(1, 10) : $urandom_range(1, 5);
        if (style < 63)
            h = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        else
            h = $urandom;
        for (int k = 0; k < len; k++)
        begin
            if (style < 70)
            begin
                c = pick_class();
                if (k > 0)
                    h = h + $urandom_range(0, 32'h0006_0000) - 32'h0001_0000;
            end
            else if (style < 85)
            begin
                c = cls_t'($urandom_range(3));
                h = $urandom;
            end
            else
            begin
                c = cls_t'($urandom_range(3));
                case ($urandom_range(3))
                    0:       h = {1'b1, 31'd0};
                    1:       h = {1'b0, {31{1'b1}}};
                    2:       h = '0;
                    default: h = '1;
                endcase
            end
            push_voxel(c, h, k == len - 1, 1'b0, '0);
        end
        sent = len;
    endtask

    task automatic add_row(input row_kind_t kind, input cls_t c,
                           input logic signed [HEIGHT_W-1:0] v, input logic fin,
                           input bit typed, input ground_rpt_t want);
        stim_row_t row;
        row.kind  = kind;
        row.cls   = c;
        row.val   = v;
        row.fin   = fin;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Result side: checks each taken report word and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_grounds.size() == 0)
                begin
                    $error("report word with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_grounds.pop_front();
                    if (found !== exp_r.found)
                    begin
                        $error("found: expected %0d, got %0d", exp_r.found, found);
                        fail_count++;
                    end
                    if (ground_index !== exp_r.index)
                    begin
                        $error("ground_index: expected %0d, got %0d", exp_r.index, ground_index);
                        fail_count++;
                    end
                    if (ground_height !== exp_r.ground_h)
                    begin
                        $error("ground_height: expected %0d, got %0d", exp_r.ground_h,
                               ground_height);
                        fail_count++;
                    end
                    if (last_height !== exp_r.last_h)
                    begin
                        $error("last_height: expected %0d, got %0d", exp_r.last_h, last_height);
                        fail_count++;
                    end
                    if (clearance !== exp_r.clr)
                    begin
                        $error("clearance: expected %0d, got %0d", exp_r.clr, clearance);
                        fail_count++;
                    end
                    if (above_seen !== exp_r.obs)
                    begin
                        $error("above_seen: expected %0d, got %0d", exp_r.obs,
                               above_seen);
                        fail_count++;
                    end
                end
            end
            // A single long hold-off lets the block back up into its input.
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 60;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm_run && ($urandom_range(99) < 26);
        end
    end

    initial
    begin
        int                 n;
        int                 len;
        logic [CLR_W-1:0]   clr;
        logic               vs;
        stim_row_t          row;

        column_clear();

        // Directed table; typed reports where they follow at a glance.
        // Empty column, then a lone surface at the top height.
        add_row(ROW_VOXEL, CLS_NULL, 0, 1'b1, 1'b1, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 32'sh7FFF_FFFF, 1'b1, 1'b1,
                mk_rpt(1'b1, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, 1'b0));
        // Break across the full height range, then skipped voxels up to the column end.
        add_row(ROW_VOXEL, CLS_OCCUPIED, 32'sh8000_0000, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 32'sh7FFF_FFFF, 1'b0, 1'b1,
                mk_rpt(1'b1, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, '1, 1'b1));
        add_row(ROW_VOXEL, CLS_FREE, 5, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_UNOBSERVED, 7, 1'b1, 1'b0, '0);
        // Largest clearance: no break while surfaces replace the candidate, then a break on a last voxel.
        add_row(ROW_SET_CLEARANCE, CLS_NULL, 32'sh7FFF_FFFF, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 100, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 50, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_FREE, -1, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 32'sh7FFF_FFFF, 1'b1, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 32'sh8000_0000, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 32'sh7FFF_FFFF, 1'b1, 1'b1,
                mk_rpt(1'b1, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, '1, 1'b1));
        // Virtual surfaces after unobserved and null space.
        add_row(ROW_SET_VIRTUAL, CLS_NULL, 1, 1'b0, 1'b0, '0);
        add_row(ROW_SET_CLEARANCE, CLS_NULL, 32'sh0001_0000, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_UNOBSERVED, 0, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_FREE, 32'sh0002_0000, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_FREE, 32'sh0003_0000, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 32'sh0003_8000, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_OCCUPIED, 0, 1'b1, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_NULL, 0, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_FREE, 32'sh0000_0100, 1'b1, 1'b0, '0);
        // Back to reset settings: a lone free voxel is no candidate.
        add_row(ROW_SET_CLEARANCE, CLS_NULL, 0, 1'b0, 1'b0, '0);
        add_row(ROW_SET_VIRTUAL, CLS_NULL, 0, 1'b0, 1'b0, '0);
        add_row(ROW_VOXEL, CLS_FREE, 1, 1'b1, 1'b1, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            case (row.kind)
                ROW_VOXEL:         push_voxel(row.cls, row.val, row.fin, row.typed, row.want);
                ROW_SET_CLEARANCE: write_reg(REG_MIN_CLEARANCE, row.val);
                ROW_SET_VIRTUAL:   write_reg(REG_VIRTUAL_SURF, row.val);
                default:           ;
            endcase
        end

        // A column longer than the counter can track, ground on its last voxel.
        for (int k = 0; k < COLUMN_DEPTH + 6; k++)
        begin
            if (k == COLUMN_DEPTH + 5)
                push_voxel(CLS_OCCUPIED, $urandom, 1'b1, 1'b0, '0);
            else
                push_voxel(cls_t'($urandom_range(1)), $urandom, 1'b0, 1'b0, '0);
        end

        // Random phases, each under its own settings; the calm phase runs longest.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       clr = '0;
                1:       clr = '1;
                default: clr = $urandom_range(1) ? CLR_W'($urandom_range(0, 32'h0003_0000))
                                                 : CLR_W'($urandom);
            endcase
            vs = (p < 2) ? p[0] : 1'($urandom_range(1));
            write_reg(REG_MIN_CLEARANCE, {1'b0, clr});
            write_reg(REG_VIRTUAL_SURF, {31'd0, vs});
            calm_run = (p == 2);
            n = 0;
            // Report-heavy burst while the result side holds off.
            if (p == 5)
            begin
                hold_req = 1'b1;
                for (int k = 0; k < 30; k++)
                    push_voxel(pick_class(), $urandom, 1'b1, 1'b0, '0);
                n = 30;
            end
            while (n < ((p == 2) ? 80 : 30))
            begin
                send_column(len);
                n += len;
            end
        end
        calm_run = 1'b0;

        settle_block();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
